/* design/qrcw_pkg.sv */
// ----------------------------------------------------------------------------
// qrcw_pkg
// Shared types and constants of the congestion window unit
// ----------------------------------------------------------------------------
package qrcw_pkg;

   localparam int WW = 32;
   localparam int TW = 64;
   localparam int CSR_DATA_W = 21;
   localparam int CSR_IDX_W = 3;
   localparam int QDEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MDS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MINW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PF    = 3'd5;

   // register values after reset
   localparam logic [15:0] MDS_RST   = 16'd1200;
   localparam logic [16:0] MINW_RST  = 17'd2400;
   localparam logic [20:0] INITW_RST = 21'd12000;
   localparam logic [13:0] DELAY_RST = 14'd25;
   localparam logic [15:0] GRAN_RST  = 16'd1000;
   localparam logic [3:0]  PF_RST    = 4'd3;

   localparam logic [1:0] ACT_SENT    = 2'd0;
   localparam logic [1:0] ACT_ACKED   = 2'd1;
   localparam logic [1:0] ACT_LOST    = 2'd2;
   localparam logic [1:0] ACT_MIGRATE = 2'd3;

   typedef struct packed {
      logic [1:0]    action;
      logic          flight_counted;
      logic [15:0]   packet_bytes;
      logic [TW-1:0] sent_time_us;
      logic          app_capped;
      logic          wants_ack;
      logic          group_end;
      logic [TW-1:0] now_us;
      logic [31:0]   smoothed_rtt_us;
      logic [31:0]   rtt_variance_us;
      logic [TW-1:0] first_sample_time_us;
      logic          sender_blocked;
   } req_type;

   typedef struct packed {
      logic [31:0] window_bytes;
      logic [31:0] flight_bytes;
      logic [32:0] window_left;
      logic [31:0] threshold_bytes;
      logic        wake_sender;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      req_type     req;
      logic        is_sent;
      logic        is_ack;
      logic        is_loss;
      logic        is_mig;
      logic [TW+1:0] period;
   } item_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_ADD   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

endpackage

/* design/qrcw_if.sv */
// ----------------------------------------------------------------------------
// qrcw_if
// Valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface qrcw_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/quic_reno_congestion_window_unit.sv */
// ----------------------------------------------------------------------------
// quic_reno_congestion_window_unit
// NewReno congestion window, threshold and bytes in flight for a QUIC sender
// ----------------------------------------------------------------------------
// One response beat per request beat, in order. A beat passes through the
// front end (input register, then a two-entry queue) and the back end
// (pick-up, update, response register). The back end holds one item at a
// time: it pops no new item from the queue until the response of the last
// one has been registered. An ack group end in congestion avoidance also
// runs the bit-serial divider of the avoidance increase (a multiply step,
// 48 quotient bits, an add step).
module quic_reno_congestion_window_unit (
   input  logic        clock,
   input  logic        reset,
   qrcw_if.sink        req,
   qrcw_if.source      rsp,
   input  logic                              csr_write,
   input  logic [qrcw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [qrcw_pkg::CSR_DATA_W-1:0]   csr_data
);
   logic [15:0] mds_ff, gran_ff;
   logic [16:0] minw_ff;
   logic [20:0] initw_ff;
   logic [13:0] delay_ff;
   logic [3:0]  pf_ff;
   logic        q_valid, q_pop;
   qrcw_pkg::item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         mds_ff <= qrcw_pkg::MDS_RST;
         minw_ff <= qrcw_pkg::MINW_RST;
         initw_ff <= qrcw_pkg::INITW_RST;
         delay_ff <= qrcw_pkg::DELAY_RST;
         gran_ff <= qrcw_pkg::GRAN_RST;
         pf_ff <= qrcw_pkg::PF_RST;
      end else if (csr_write) begin
         case (csr_index)
            qrcw_pkg::CSR_MDS:   mds_ff <= csr_data[15:0];
            qrcw_pkg::CSR_MINW:  minw_ff <= csr_data[16:0];
            qrcw_pkg::CSR_INITW: initw_ff <= csr_data[20:0];
            qrcw_pkg::CSR_DELAY: delay_ff <= csr_data[13:0];
            qrcw_pkg::CSR_GRAN:  gran_ff <= csr_data[15:0];
            qrcw_pkg::CSR_PF:    pf_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   qrcw_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .gran_ff_i(gran_ff), .delay_i(delay_ff), .pf_i(pf_ff),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   qrcw_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .rsp(rsp),
      .mds_i(mds_ff), .minw_i(minw_ff), .initw_i(initw_ff)
   );
endmodule

/* design/qrcw_front.sv */
// ----------------------------------------------------------------------------
// qrcw_front
// Accepts request beats, decodes the action, works out the persistent
// congestion period and queues the item for the back end
// ----------------------------------------------------------------------------
module qrcw_front (
   input  logic                  clock,
   input  logic                  reset,
   qrcw_if.sink                  req,
   input  logic [15:0]           gran_ff_i,
   input  logic [13:0]           delay_i,
   input  logic [3:0]            pf_i,
   output logic                  q_valid,
   output qrcw_pkg::item_type    q_item,
   input  logic                  q_pop
);
   // stage 1: register beat and period base; stage 2: multiply by factor
   logic                s1_ff, s1_in;
   qrcw_pkg::req_type   r1_ff;
   logic [qrcw_pkg::TW-1:0] base_ff;
   logic [qrcw_pkg::TW+1:0] v4;
   logic [qrcw_pkg::TW-1:0] var_term, base_in;
   qrcw_pkg::item_type  it;
   qrcw_pkg::item_type  mem_ff [qrcw_pkg::QDEPTH];
   logic                wp_ff, rp_ff;
   logic [1:0]          cnt_ff;
   logic                push, s1_take;

   assign v4 = {{(qrcw_pkg::TW-32+2){1'b0}}, req.payload.rtt_variance_us} << 2;
   always_comb begin
      var_term = (v4[qrcw_pkg::TW-1:0] > {{(qrcw_pkg::TW-16){1'b0}}, gran_ff_i})
         ? v4[qrcw_pkg::TW-1:0] : {{(qrcw_pkg::TW-16){1'b0}}, gran_ff_i};
      base_in = {{(qrcw_pkg::TW-32){1'b0}}, req.payload.smoothed_rtt_us} + var_term
         + qrcw_pkg::TW'({10'd0, delay_i} * 24'd1000);
   end

   assign push = s1_ff && (cnt_ff != 2'(qrcw_pkg::QDEPTH));
   assign s1_take = !s1_ff || push;
   assign req.ready = s1_take;
   assign s1_in = req.valid ? 1'b1 : (push ? 1'b0 : s1_ff);

   always_comb begin
      it.req = r1_ff;
      it.is_sent = r1_ff.action == qrcw_pkg::ACT_SENT;
      it.is_ack  = r1_ff.action == qrcw_pkg::ACT_ACKED;
      it.is_loss = r1_ff.action == qrcw_pkg::ACT_LOST;
      it.is_mig  = r1_ff.action == qrcw_pkg::ACT_MIGRATE;
      it.period  = (qrcw_pkg::TW+2)'(base_ff) * (qrcw_pkg::TW+2)'(pf_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (s1_take) s1_ff <= s1_in;
         else s1_ff <= s1_ff;
         if (push) wp_ff <= !wp_ff;
         if (q_pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
      if (req.valid && s1_take) begin
         r1_ff <= req.payload;
         base_ff <= base_in;
      end
      if (push) mem_ff[wp_ff] <= it;
   end

   assign q_valid = cnt_ff != '0;
   assign q_item = mem_ff[rp_ff];
endmodule

/* design/qrcw_back.sv */
// ----------------------------------------------------------------------------
// qrcw_back
// Carries out queued items against the window state; ack group ends in
// congestion avoidance run a bit-serial divider
// ----------------------------------------------------------------------------
module qrcw_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  qrcw_pkg::item_type    q_item,
   output logic                  q_pop,
   qrcw_if.source                rsp,
   input  logic [15:0]           mds_i,
   input  logic [16:0]           minw_i,
   input  logic [20:0]           initw_i
);
   localparam int W = qrcw_pkg::WW;
   localparam int T = qrcw_pkg::TW;
   localparam logic [W-1:0] WMAX = '1;

   qrcw_pkg::state_type st_ff;
   qrcw_pkg::item_type  it_ff;
   logic [W-1:0] cwnd_ff, ssth_ff, out_ff, acc_ff;
   logic [T-1:0] rstart_ff, llt_ff, el_ff, ll_ff;
   logic         full_ff, open_ff;
   logic [W+16-1:0] prod_ff;
   logic [W+16-1:0] rem_ff;
   logic [W+16-1:0] quo_ff;
   logic [6:0]   bit_ff;
   logic [W-1:0] div_ff;
   logic         wake_ff;
   logic         rv_ff;
   qrcw_pkg::rsp_type rsp_ff;

   logic [W-1:0] initw, minw, half;
   logic [W+16:0] rem_sh;

   assign initw = W'(initw_i);
   assign minw  = W'(minw_i);
   assign half  = cwnd_ff >> 1;
   assign rem_sh = {rem_ff, prod_ff[W+16-1]};

   function automatic logic [W-1:0] sat_add(logic [W-1:0] a, logic [W-1:0] b);
      logic [W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[W] ? WMAX : s[W-1:0];
   endfunction

   function automatic logic [W-1:0] sat_sub(logic [W-1:0] a, logic [W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   assign q_pop = (st_ff == qrcw_pkg::ST_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= qrcw_pkg::ST_IDLE;
         cwnd_ff <= W'(qrcw_pkg::INITW_RST);
         ssth_ff <= WMAX;
         out_ff <= '0;
         rstart_ff <= '0;
         acc_ff <= '0;
         full_ff <= 1'b0;
         open_ff <= 1'b0;
         llt_ff <= '0;
         el_ff <= '1;
         ll_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (rv_ff && rsp.ready && st_ff != qrcw_pkg::ST_OUT) rv_ff <= 1'b0;
         case (st_ff)
            qrcw_pkg::ST_IDLE: begin
               if (q_valid) begin
                  it_ff <= q_item;
                  st_ff <= qrcw_pkg::ST_EXEC;
               end
            end
            qrcw_pkg::ST_EXEC: begin : exec
               logic [W-1:0] o, a, cw, ss;
               logic [T-1:0] lt, e, l, rs;
               logic f, op, wk;
               qrcw_pkg::state_type nx;
               o = out_ff; a = acc_ff; cw = cwnd_ff; ss = ssth_ff;
               lt = llt_ff; e = el_ff; l = ll_ff; rs = rstart_ff; f = full_ff;
               op = open_ff; wk = 1'b0; nx = qrcw_pkg::ST_OUT;
               if (it_ff.is_sent) begin
                  if (it_ff.req.flight_counted) o = sat_add(o, W'(it_ff.req.packet_bytes));
               end else if (it_ff.is_mig) begin
                  cw = initw; rs = '0; ss = WMAX;
               end else begin
                  if (!open_ff) begin
                     f = o >= cw;
                     op = 1'b1;
                  end
                  if (it_ff.is_ack) begin
                     if (it_ff.req.flight_counted) begin
                        o = sat_sub(o, W'(it_ff.req.packet_bytes));
                        if (f && !it_ff.req.app_capped && it_ff.req.sent_time_us > rs)
                           a = sat_add(a, W'(it_ff.req.packet_bytes));
                     end
                     if (it_ff.req.group_end) begin
                        wk = it_ff.req.sender_blocked;
                        op = 1'b0;
                        if (cw < ss) begin
                           cw = sat_add(cw, a);
                           a = '0;
                        end else begin
                           nx = qrcw_pkg::ST_MUL;
                        end
                     end
                  end else begin
                     if (it_ff.req.flight_counted) begin
                        o = sat_sub(o, W'(it_ff.req.packet_bytes));
                        if (it_ff.req.sent_time_us > lt) lt = it_ff.req.sent_time_us;
                     end
                     if (it_ff.req.sent_time_us > it_ff.req.first_sample_time_us
                         && it_ff.req.wants_ack) begin
                        if (it_ff.req.sent_time_us < e) e = it_ff.req.sent_time_us;
                        if (it_ff.req.sent_time_us > l) l = it_ff.req.sent_time_us;
                     end
                     if (it_ff.req.group_end) begin
                        if (lt != '0 && lt > rs) begin
                           rs = it_ff.req.now_us;
                           ss = (half > minw) ? half : minw;
                           cw = ss;
                        end
                        if (it_ff.req.first_sample_time_us != '0 && e <= l
                            && {2'b00, l - e} >= it_ff.period)
                           cw = minw;
                        lt = '0; e = '1; l = '0;
                        op = 1'b0;
                     end
                  end
               end
               out_ff <= o; acc_ff <= a; cwnd_ff <= cw; ssth_ff <= ss;
               llt_ff <= lt; el_ff <= e; ll_ff <= l; rstart_ff <= rs; full_ff <= f;
               open_ff <= op; wake_ff <= wk; st_ff <= nx;
            end
            qrcw_pkg::ST_MUL: begin
               prod_ff <= (W+16)'(acc_ff) * (W+16)'(mds_i);
               div_ff <= (cwnd_ff == '0) ? W'(1) : cwnd_ff;
               rem_ff <= '0;
               quo_ff <= '0;
               bit_ff <= 7'(W+16);
               acc_ff <= '0;
               st_ff <= qrcw_pkg::ST_DIV;
            end
            qrcw_pkg::ST_DIV: begin
               // restoring division, one quotient bit a cycle
               if (rem_sh >= {{17{1'b0}}, div_ff}) begin
                  rem_ff <= (W+16)'(rem_sh - {{17{1'b0}}, div_ff});
                  quo_ff <= {quo_ff[W+16-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[W+16-1:0];
                  quo_ff <= {quo_ff[W+16-2:0], 1'b0};
               end
               prod_ff <= prod_ff << 1;
               bit_ff <= bit_ff - 7'd1;
               if (bit_ff == 7'd1) st_ff <= qrcw_pkg::ST_ADD;
            end
            qrcw_pkg::ST_ADD: begin
               cwnd_ff <= (quo_ff[W+16-1:W] != '0) ? WMAX : sat_add(cwnd_ff, quo_ff[W-1:0]);
               st_ff <= qrcw_pkg::ST_OUT;
            end
            qrcw_pkg::ST_OUT: begin
               if (!rv_ff || rsp.ready) begin
                  rv_ff <= 1'b1;
                  rsp_ff.window_bytes <= 32'(cwnd_ff);
                  rsp_ff.flight_bytes <= 32'(out_ff);
                  rsp_ff.window_left <= 33'({1'b0, cwnd_ff} - {1'b0, out_ff});
                  rsp_ff.threshold_bytes <= 32'(ssth_ff);
                  rsp_ff.wake_sender <= wake_ff;
                  st_ff <= qrcw_pkg::ST_IDLE;
               end
            end
            default: st_ff <= qrcw_pkg::ST_IDLE;
         endcase
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.payload = rsp_ff;
endmodule
